### src/bpcm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, mode codes, sequencer states and the memory request type
// for the byte permission checked memory. No dependencies.
package bpcm_pkg;

	localparam int MEM_BYTES      = 65536;
	localparam int MAX_DATA_BYTES = 8;

	localparam int ADDR_W = $clog2(MEM_BYTES);
	localparam int BND_W  = $clog2(MEM_BYTES + 1);
	localparam int LEN_W  = 17;
	localparam int SIZE_W = 17;
	localparam int MODE_W = 3;
	localparam int FLG_W  = 8;
	localparam int WORD_W = 64;
	localparam int IDX_W  = 3;
	localparam int CMP_W  = (BND_W > LEN_W) ? BND_W : LEN_W;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);

	localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CREAD  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CWRITE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SETF   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CHKF   = 3'd5;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_PERM,
		ST_PDRAIN,
		ST_READ,
		ST_WRITE,
		ST_SETF,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

endpackage

### src/bpcm_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on bpcm_pkg for field widths.
interface bpcm_req_if;
	import bpcm_pkg::*;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [WORD_W-1:0]   address;
	logic [LEN_W-1:0]    access_length;
	logic [FLG_W-1:0]    flag_bits;
	logic [WORD_W-1:0]   write_data;
	modport source (output valid, mode, address, access_length, flag_bits, write_data,
		input ready);
	modport sink (input valid, mode, address, access_length, flag_bits, write_data,
		output ready);
endinterface

interface bpcm_rsp_if;
	import bpcm_pkg::*;
	logic              valid;
	logic              ready;
	logic              ok;
	logic [WORD_W-1:0] read_data;
	modport source (output valid, ok, read_data, input ready);
	modport sink (input valid, ok, read_data, output ready);
endinterface

interface bpcm_cfg_if;
	import bpcm_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/bpcm_ram.sv
`timescale 1ns / 1ps
// Single-port byte RAM with registered read data, no reset.
// No dependencies.
module bpcm_ram #(
	parameter int AW = 16,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

### src/bpcm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer and datapath: bounds check, byte loop over the stores, result register.
// Depends on bpcm_pkg and the channel interfaces in bpcm_ifs.sv.
module bpcm_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	bpcm_req_if.sink                 req,
	bpcm_rsp_if.source               rsp,
	bpcm_cfg_if.sink                 cfg,
	output bpcm_pkg::mem_req_t       data_req,
	output bpcm_pkg::mem_req_t       perm_req,
	input  logic [7:0]               data_rdata,
	input  logic [7:0]               perm_rdata
);
	import bpcm_pkg::*;

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   clr_q;
	logic [SIZE_W-1:0]   mem_size_q;
	logic [MODE_W-1:0]   mode_q;
	logic [WORD_W-1:0]   addr_q;
	logic [LEN_W-1:0]    len_q;
	logic [FLG_W-1:0]    flg_q;
	logic [WORD_W-1:0]   wdata_q;
	logic [LEN_W-1:0]    cnt_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic                fail_q;
	logic                ok_q;
	logic [WORD_W-1:0]   acc_q;
	logic                pchk_s1;
	logic                rd_s1;
	logic [IDX_W-1:0]    ridx_s1;
	logic                out_valid_q;
	logic                out_ok_q;
	logic [WORD_W-1:0]   out_data_q;

	logic [CMP_W-1:0]    bound;
	logic [CMP_W-1:0]    addr_c;
	logic                bounds_ok;
	logic                mode_ok;
	logic                loop_end;
	logic                clr_last;
	logic                out_free;
	logic [5:0]          byte_sel;

	assign cfg.ready = 1'b1;

	always_comb begin
		bound = (CMP_W'(mem_size_q) < CMP_W'(MEM_BYTES)) ? CMP_W'(mem_size_q)
			: CMP_W'(MEM_BYTES);
		addr_c    = addr_q[CMP_W-1:0];
		bounds_ok = (addr_q[WORD_W-1:CMP_W] == '0) && (addr_c <= bound)
			&& (CMP_W'(len_q) <= (bound - addr_c));
		mode_ok   = (mode_q <= MODE_CHKF)
			&& !((mode_q <= MODE_CWRITE) && (len_q > LEN_W'(MAX_DATA_BYTES)));
	end

	assign loop_end = (cnt_q == len_q);
	assign clr_last = (clr_q == ADDR_W'(MEM_BYTES - 1));
	assign out_free = !out_valid_q || rsp.ready;
	assign byte_sel = {cnt_q[IDX_W-1:0], 3'b000};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!(bounds_ok && mode_ok)) begin
					state_d = ST_DONE;
				end else if (mode_q == MODE_READ) begin
					state_d = ST_READ;
				end else if (mode_q == MODE_WRITE) begin
					state_d = ST_WRITE;
				end else if (mode_q == MODE_SETF) begin
					state_d = ST_SETF;
				end else begin
					state_d = ST_PERM;
				end
			end
			ST_PERM: begin
				if (loop_end) state_d = ST_PDRAIN;
			end
			ST_PDRAIN: begin
				if (fail_q || mode_q == MODE_CHKF) begin
					state_d = ST_DONE;
				end else if (mode_q == MODE_CREAD) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_READ, ST_WRITE, ST_SETF: begin
				if (loop_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs toward the channels and the stores
	always_comb begin
		req.ready = 1'b0;
		data_req  = '0;
		perm_req  = '0;
		data_req.addr = ptr_q;
		perm_req.addr = ptr_q;
		case (state_q)
			ST_CLEAR: begin
				data_req.we   = 1'b1;
				data_req.addr = clr_q;
				perm_req.we   = 1'b1;
				perm_req.addr = clr_q;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_PERM: begin
				perm_req.re = !loop_end;
			end
			ST_READ: begin
				data_req.re = !loop_end;
			end
			ST_WRITE: begin
				data_req.we    = !loop_end;
				data_req.wdata = wdata_q[byte_sel +: 8];
			end
			ST_SETF: begin
				perm_req.we    = !loop_end;
				perm_req.wdata = flg_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.ok        = out_ok_q;
	assign rsp.read_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			mem_size_q  <= SIZE_RESET;
			out_valid_q <= 1'b0;
			pchk_s1     <= 1'b0;
			rd_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				mem_size_q <= cfg.data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			pchk_s1 <= perm_req.re;
			rd_s1   <= data_req.re;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and loop registers
	always_ff @(posedge clk) begin
		ridx_s1 <= cnt_q[IDX_W-1:0];
		if (pchk_s1 && ((perm_rdata & flg_q) != flg_q)) begin
			fail_q <= 1'b1;
		end
		if (rd_s1) begin
			acc_q[{ridx_s1, 3'b000} +: 8] <= data_rdata;
		end
		case (state_q)
			ST_IDLE: begin
				mode_q  <= req.mode;
				addr_q  <= req.address;
				len_q   <= req.access_length;
				flg_q   <= req.flag_bits;
				wdata_q <= req.write_data;
				ptr_q   <= req.address[ADDR_W-1:0];
				cnt_q   <= '0;
				fail_q  <= 1'b0;
				acc_q   <= '0;
			end
			ST_CHECK: begin
				ok_q <= bounds_ok && mode_ok;
			end
			ST_PERM, ST_READ, ST_WRITE, ST_SETF: begin
				if (!loop_end) begin
					cnt_q <= cnt_q + 1'b1;
					ptr_q <= ptr_q + 1'b1;
				end
			end
			ST_PDRAIN: begin
				// restart the byte loop for the data pass
				ok_q  <= ok_q && !fail_q;
				cnt_q <= '0;
				ptr_q <= addr_q[ADDR_W-1:0];
			end
			ST_DONE: begin
				if (out_free) begin
					out_ok_q   <= ok_q;
					out_data_q <= ok_q ? acc_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### src/byte_permission_checked_memory.sv
`timescale 1ns / 1ps
// Byte permission checked memory: data and flag stores, one byte per cycle.
// A checked read/write makes a flag pass and then a data pass (no data pass on a flag
// miss); a failing bounds or length check goes straight to the response.
// One request at a time: the next is accepted in the same cycle as the response beat is first offered.
// Reset: both stores are swept to zero, one byte a cycle, before the first request is
// accepted; the size register resets to 65536.
module byte_permission_checked_memory (
	input  logic        clk,
	input  logic        arst_n,
	bpcm_req_if.sink    req,
	bpcm_rsp_if.source  rsp,
	bpcm_cfg_if.sink    cfg
);
	import bpcm_pkg::*;

	mem_req_t   data_req;
	mem_req_t   perm_req;
	logic [7:0] data_rdata;
	logic [7:0] perm_rdata;

	bpcm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.data_req   (data_req),
		.perm_req   (perm_req),
		.data_rdata (data_rdata),
		.perm_rdata (perm_rdata)
	);

	bpcm_ram #(.AW(ADDR_W), .DW(8)) u_data_ram (
		.clk   (clk),
		.we    (data_req.we),
		.re    (data_req.re),
		.addr  (data_req.addr),
		.wdata (data_req.wdata),
		.rdata (data_rdata)
	);

	bpcm_ram #(.AW(ADDR_W), .DW(FLG_W)) u_perm_ram (
		.clk   (clk),
		.we    (perm_req.we),
		.re    (perm_req.re),
		.addr  (perm_req.addr),
		.wdata (perm_req.wdata),
		.rdata (perm_rdata)
	);

endmodule

### sim/bpcm_checker.sv
`timescale 1ns / 1ps
// Checker for the byte permission checked memory: watches the request, response and
// size channels, keeps its own copy of both byte stores and scores every response.
// Depends on bpcm_pkg and the channel interfaces in bpcm_ifs.sv.
module bpcm_checker (
	input  logic clk,
	input  logic arst_n,
	bpcm_req_if  req,
	bpcm_rsp_if  rsp,
	bpcm_cfg_if  cfg,
	output int   errors,
	output int   pending
);
	import bpcm_pkg::*;

	typedef struct packed {
		logic              ok;
		logic [WORD_W-1:0] read_data;
	} answer_t;

	logic [7:0]        data_mem [MEM_BYTES];
	logic [FLG_W-1:0]  flag_mem [MEM_BYTES];
	logic [SIZE_W-1:0] size_reg;
	answer_t           answer_q [$];
	int                answered;

	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0t] MISMATCH response %0d: %s", $time, answered, what);
	endtask

	function automatic logic flags_cover(input int start, input int count,
			input logic [FLG_W-1:0] need);
		for (int i = 0; i < count; i++)
			if ((flag_mem[start + i] & need) != need)
				return 1'b0;
		return 1'b1;
	endfunction

	// Work out the answer to one request and apply its side effects to the stores.
	function automatic answer_t serve_request(input logic [MODE_W-1:0] mode,
			input logic [WORD_W-1:0] addr, input logic [LEN_W-1:0] len,
			input logic [FLG_W-1:0] need, input logic [WORD_W-1:0] wdata);
		answer_t         ans;
		logic [WORD_W:0] limit;
		int              start;
		int              count;
		ans = '0;
		limit = (size_reg > SIZE_W'(MEM_BYTES)) ? (WORD_W+1)'(MEM_BYTES)
			: (WORD_W+1)'(size_reg);
		if (mode > MODE_CHKF)
			return ans;
		// no wrap: compare against the room left above the address
		if ({1'b0, addr} > limit)
			return ans;
		if ((WORD_W+1)'(len) > limit - {1'b0, addr})
			return ans;
		start = int'(addr[ADDR_W-1:0]);
		count = int'(len);
		case (mode)
			MODE_READ, MODE_WRITE, MODE_CREAD, MODE_CWRITE: begin
				if (len > LEN_W'(MAX_DATA_BYTES))
					return ans;
				if ((mode == MODE_CREAD || mode == MODE_CWRITE) &&
						!flags_cover(start, count, need))
					return ans;
				for (int i = 0; i < count; i++) begin
					if (mode == MODE_READ || mode == MODE_CREAD)
						ans.read_data[8*i +: 8] = data_mem[start + i];
					else
						data_mem[start + i] = wdata[8*i +: 8];
				end
				ans.ok = 1'b1;
			end
			MODE_SETF: begin
				for (int i = 0; i < count; i++)
					flag_mem[start + i] = need;
				ans.ok = 1'b1;
			end
			default: ans.ok = flags_cover(start, count, need);
		endcase
		return ans;
	endfunction

	always @(posedge clk) begin
		answer_t want;
		if (!arst_n) begin
			for (int i = 0; i < MEM_BYTES; i++) begin
				data_mem[i] = '0;
				flag_mem[i] = '0;
			end
			size_reg = SIZE_RESET;
			answer_q.delete();
			errors = 0;
			answered = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				size_reg = cfg.data;
			if (req.valid && req.ready)
				answer_q.push_back(serve_request(req.mode, req.address, req.access_length,
					req.flag_bits, req.write_data));
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					report_mismatch($sformatf("unrequested beat ok=%b read_data=%h",
						rsp.ok, rsp.read_data));
				end else begin
					want = answer_q.pop_front();
					if (rsp.ok !== want.ok)
						report_mismatch($sformatf("ok %b, expected %b", rsp.ok, want.ok));
					if (rsp.read_data !== want.read_data)
						report_mismatch($sformatf("read_data %h, expected %h",
							rsp.read_data, want.read_data));
				end
				answered++;
			end
		end
		pending = answer_q.size();
	end

endmodule

### sim/tb_byte_permission_checked_memory.sv
`timescale 1ns / 1ps
// Testbench top for the byte permission checked memory: clock, reset, request and
// size stimulus, response back-pressure and the verdict. Depends on bpcm_pkg,
// bpcm_ifs.sv, the block itself and bpcm_checker.
module tb_byte_permission_checked_memory;
	import bpcm_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS   = 148;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 64;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [WORD_W-1:0] address;
		logic [LEN_W-1:0]  len;
		logic [FLG_W-1:0]  flags;
		logic [WORD_W-1:0] wdata;
	} request_t;

	logic clk = 1'b0;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   items_sent;
	bit   hold_rsp;
	int   errors;
	int   pending;

	bpcm_req_if req_ch ();
	bpcm_rsp_if rsp_ch ();
	bpcm_cfg_if cfg_ch ();

	byte_permission_checked_memory dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	bpcm_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic request_t make_req(input logic [MODE_W-1:0] mode,
			input logic [WORD_W-1:0] address, input logic [LEN_W-1:0] len,
			input logic [FLG_W-1:0] flags, input logic [WORD_W-1:0] wdata);
		request_t r;
		r.mode = mode;
		r.address = address;
		r.len = len;
		r.flags = flags;
		r.wdata = wdata;
		return r;
	endfunction

	// Flags mostly come from a small pool so that checks pass often enough.
	function automatic logic [FLG_W-1:0] pick_flags();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'h03;
			3: return 8'h05;
			4: return 8'h80;
			5: return 8'hFF;
			default: return FLG_W'($urandom);
		endcase
	endfunction

	function automatic request_t random_request(input int bnd);
		request_t r;
		int       pick;
		int       lo;
		r.wdata = {$urandom, $urandom};
		r.flags = pick_flags();
		pick = $urandom_range(99);
		if (pick < 5) begin
			// wild address: any mode, any length, always out of range
			r.mode = MODE_W'($urandom_range(7));
			r.address = {$urandom, $urandom};
			if (r.address[63:32] == '0)
				r.address[63] = 1'b1;
			r.len = LEN_W'($urandom);
		end else if (pick < 10) begin
			r.mode = (pick == 9) ? (($urandom_range(1) == 0) ? MODE_SPARE_A : MODE_SPARE_B)
				: MODE_W'($urandom_range(3));
			r.address = WORD_W'($urandom_range(bnd));
			r.len = LEN_W'($urandom);
		end else begin
			pick = $urandom_range(99);
			if (pick < 20)
				r.mode = MODE_READ;
			else if (pick < 40)
				r.mode = MODE_WRITE;
			else if (pick < 55)
				r.mode = MODE_CREAD;
			else if (pick < 70)
				r.mode = MODE_CWRITE;
			else if (pick < 85)
				r.mode = MODE_SETF;
			else
				r.mode = MODE_CHKF;
			if (r.mode <= MODE_CWRITE)
				r.len = ($urandom_range(19) == 0) ? LEN_W'($urandom_range(16, 9))
					: LEN_W'($urandom_range(MAX_DATA_BYTES));
			else
				r.len = ($urandom_range(49) == 0) ? LEN_W'($urandom_range(2048))
					: LEN_W'($urandom_range(24));
			// keep most traffic in a small hot window and at the top of memory
			pick = $urandom_range(99);
			lo = (bnd > 16) ? bnd - 16 : 0;
			if (pick < 60)
				r.address = WORD_W'($urandom_range((bnd < 63) ? bnd : 63));
			else if (pick < 85)
				r.address = WORD_W'($urandom_range(bnd, lo));
			else
				r.address = WORD_W'($urandom_range(bnd));
		end
		return r;
	endfunction

	// Offer one beat, with random gaps ahead of it; return at the next falling edge.
	task automatic send(input request_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= r.mode;
		req_ch.address <= r.address;
		req_ch.access_length <= r.len;
		req_ch.flag_bits <= r.flags;
		req_ch.write_data <= r.wdata;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop the request valid, drain every outstanding response, then write the size.
	task automatic set_size(input logic [SIZE_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Stall the response side long enough that the block backs up into its input.
	initial begin
		wait (items_sent >= 60);
		@(posedge clk);
		hold_rsp = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rsp = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int sizes [RANDOM_PHASES];
		int bnd;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_READ;
		req_ch.address = '0;
		req_ch.access_length = '0;
		req_ch.flag_bits = '0;
		req_ch.write_data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		tx_idle_pct = 25;
		rx_idle_pct = 77;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset contents, full-range flags, checked access, bounds edges
		send(make_req(MODE_READ, 0, 8, 8'h00, 0));
		send(make_req(MODE_WRITE, 0, 8, 8'h00, '1));
		send(make_req(MODE_READ, 0, 8, 8'h00, 0));
		send(make_req(MODE_CREAD, 0, 1, 8'h01, 0));
		send(make_req(MODE_CREAD, 0, 4, 8'h00, 0));
		send(make_req(MODE_SETF, 0, LEN_W'(MEM_BYTES), 8'hFF, 0));
		send(make_req(MODE_CHKF, 0, LEN_W'(MEM_BYTES), 8'hFF, 0));
		send(make_req(MODE_SETF, 16, 4, 8'h05, 0));
		send(make_req(MODE_CWRITE, 14, 8, 8'h05, 64'h0123_4567_89AB_CDEF));
		send(make_req(MODE_CWRITE, 14, 8, 8'h07, 64'hFEDC_BA98_7654_3210));
		send(make_req(MODE_CREAD, 14, 8, 8'h04, 0));
		send(make_req(MODE_CHKF, 16, 4, 8'h06, 0));
		send(make_req(MODE_READ, 0, 9, 8'h00, 0));
		send(make_req(MODE_WRITE, WORD_W'(MEM_BYTES - 8), 8, 8'h00,
			64'h8000_0000_0000_0001));
		send(make_req(MODE_READ, WORD_W'(MEM_BYTES - 7), 8, 8'h00, 0));
		send(make_req(MODE_READ, WORD_W'(MEM_BYTES), 0, 8'h00, 0));
		send(make_req(MODE_READ, WORD_W'(MEM_BYTES + 1), 0, 8'h00, 0));
		send(make_req(MODE_WRITE, '1, 1, 8'h00, '1));
		send(make_req(MODE_CHKF, 0, '1, 8'h00, 0));
		send(make_req(MODE_SPARE_A, 0, 1, 8'h00, 0));
		send(make_req(MODE_SPARE_B, 0, 1, 8'h00, 0));
		send(make_req(MODE_WRITE, 100, 0, 8'h00, '1));
		send(make_req(MODE_CREAD, WORD_W'(MEM_BYTES - 8), 8, 8'hFF, 0));
		set_size(0);
		send(make_req(MODE_READ, 0, 0, 8'h00, 0));
		send(make_req(MODE_SETF, 0, 1, 8'h01, 0));
		set_size('1);
		send(make_req(MODE_READ, WORD_W'(MEM_BYTES - 8), 8, 8'h00, 0));
		send(make_req(MODE_CWRITE, WORD_W'(MEM_BYTES - 1), 2, 8'h00, '1));

		sizes = '{65536, 4096, 131071, 64, 8, 65535, 1, 0, 0};
		sizes[RANDOM_PHASES - 1] = $urandom_range(65536, 1);
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 3) begin
				tx_idle_pct = 25;
				rx_idle_pct = 77;
			end else if (p < 6) begin
				tx_idle_pct = 77;
				rx_idle_pct = 25;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			set_size(SIZE_W'(sizes[p]));
			bnd = (sizes[p] > MEM_BYTES) ? MEM_BYTES : sizes[p];
			for (int n = 0; n < PHASE_ITEMS; n++)
				send(random_request(bnd));
		end

		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
